>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL. Empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> sv/fla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fla_pkg
// Types, constants and helper functions of the long name assembler.
// ----------------------------------------------------------------------------
package fla_pkg;

   localparam int MAX_FRAGMENTS_DEF = 20;
   localparam int UNITS_PER_FRAG    = 13;

   localparam logic [8:0]  CAP_RESET    = 9'd64;
   localparam logic [8:0]  CAP_MAX      = 9'd256;
   localparam logic [7:0]  BYTE_END     = 8'h00;
   localparam logic [7:0]  BYTE_DELETED = 8'hE5;
   localparam logic [7:0]  ATTR_LFN     = 8'h0F;
   localparam int          ATTR_VOL_BIT = 3;
   localparam int          ATTR_DIR_BIT = 4;
   localparam int          ORDER_HEAD_BIT = 6;
   localparam logic [7:0]  CHAR_SPACE   = 8'h20;
   localparam logic [7:0]  CHAR_DOT     = 8'h2E;
   localparam logic [15:0] SURR_LO      = 16'hD800;
   localparam logic [15:0] SURR_HI      = 16'hDFFF;
   localparam logic [15:0] UNIT_FILL    = 16'hFFFF;
   localparam logic [7:0]  UTF8_CONT    = 8'h80;
   localparam logic [7:0]  UTF8_LEAD2   = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;

   // Byte offsets of the 13 UTF-16 units inside a fragment entry.
   localparam logic [4:0] UNIT_OFFSETS [UNITS_PER_FRAG] =
      '{5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24,
        5'd28, 5'd30};

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_DEC  = 7'b0000010,
      ST_FRAG = 7'b0000100,
      ST_SUM  = 7'b0001000,
      ST_SCAN = 7'b0010000,
      ST_EMIT = 7'b0100000,
      ST_LAST = 7'b1000000
   } state_type;

   typedef enum logic [2:0] {
      K_END, K_DEL, K_FRAG, K_VOL, K_SHORT
   } kind_type;

   typedef struct packed {
      logic load;
      logic chain_clear;
      logic frag_start;
      logic frag_write;
      logic walk_start;
      logic sum_step;
      logic scan_step;
      logic long_start;
      logic short_start;
      logic emit_step;
      logic send_last;
      logic send_end;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     frag_ok;
      logic     col_last;
      logic     sum_last;
      logic     scan_done;
      logic     scan_ok;
      logic     emit_done;
      logic     out_free;
   } status_type;

   // Number of UTF-8 bytes for one BMP unit.
   function automatic logic [1:0] utf8_len(input logic [15:0] u);
      if (u < 16'h0080) return 2'd1;
      if (u < 16'h0800) return 2'd2;
      return 2'd3;
   endfunction

   // Byte b of the UTF-8 encoding of one BMP unit.
   function automatic logic [7:0] utf8_byte(input logic [15:0] u, input logic [1:0] b);
      logic [1:0] n;
      n = utf8_len(u);
      if (n == 2'd1) return u[7:0];
      if (n == 2'd2) return (b == 2'd0) ? (UTF8_LEAD2 | {3'b000, u[10:6]})
                                          : (UTF8_CONT | {2'b00, u[5:0]});
      case (b)
         2'd0:    return UTF8_LEAD3 | {4'b0000, u[15:12]};
         2'd1:    return UTF8_CONT | {2'b00, u[11:6]};
         default: return UTF8_CONT | {2'b00, u[5:0]};
      endcase
   endfunction

endpackage

>>> sv/fla_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fla_if
// Handshake channels of the long name assembler: entry words and name words.
// ----------------------------------------------------------------------------
interface fla_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] entry_bytes_0_7;
   logic [63:0] entry_bytes_8_15;
   logic [63:0] entry_bytes_16_23;
   logic [63:0] entry_bytes_24_31;

   modport source (output valid, entry_bytes_0_7, entry_bytes_8_15,
                   entry_bytes_16_23, entry_bytes_24_31, input ready);
   modport sink   (input valid, entry_bytes_0_7, entry_bytes_8_15,
                   entry_bytes_16_23, entry_bytes_24_31, output ready);
endinterface

interface fla_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [63:0] name_chunk;
   logic [3:0]  chunk_bytes;
   logic        is_last;
   logic        long_name_used;
   logic        is_directory;
   logic [7:0]  attributes;
   logic [31:0] start_cluster;
   logic [31:0] file_size;

   modport source (output valid, result_kind, name_chunk, chunk_bytes, is_last,
                   long_name_used, is_directory, attributes, start_cluster,
                   file_size, input ready);
   modport sink   (input valid, result_kind, name_chunk, chunk_bytes, is_last,
                   long_name_used, is_directory, attributes, start_cluster,
                   file_size, output ready);
endinterface

>>> sv/fla_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fla_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 260
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> sv/fla_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fla_ctrl
// Controller state machine: sequences decode, fragment store, name scan
// and name emission for one entry at a time.
// ----------------------------------------------------------------------------
module fla_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fla_pkg::status_type status,
   output fla_pkg::cmd_type    cmd
);
   import fla_pkg::*;

   state_type state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            case (status.kind)
               K_END: begin
                  if (status.out_free) begin
                     cmd.send_end = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               K_FRAG: begin
                  if (status.frag_ok) begin
                     cmd.frag_start = 1'b1;
                     state_in       = ST_FRAG;
                  end else begin
                     cmd.chain_clear = 1'b1;
                     state_in        = ST_IDLE;
                  end
               end
               K_SHORT: begin
                  cmd.walk_start = 1'b1;
                  state_in       = ST_SUM;
               end
               default: begin
                  cmd.chain_clear = 1'b1;
                  state_in        = ST_IDLE;
               end
            endcase
         end
         ST_FRAG: begin
            cmd.frag_write = 1'b1;
            if (status.col_last) state_in = ST_IDLE;
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            if (status.sum_last) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               cmd.long_start  = status.scan_ok;
               cmd.short_start = !status.scan_ok;
               state_in        = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit_step = 1'b1;
            if (status.emit_done) state_in = ST_LAST;
         end
         ST_LAST: begin
            if (status.out_free) begin
               cmd.send_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

>>> sv/fla_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fla_dp
// Datapath: entry register, chain state, unit store, name scanner, UTF-8
// and 8.3 byte sources, word packer and output register.
// ----------------------------------------------------------------------------
module fla_dp #(
   parameter int MAX_FRAGMENTS = fla_pkg::MAX_FRAGMENTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  fla_pkg::cmd_type    cmd,
   output fla_pkg::status_type status,
   input  logic [63:0]         entry_bytes_0_7,
   input  logic [63:0]         entry_bytes_8_15,
   input  logic [63:0]         entry_bytes_16_23,
   input  logic [63:0]         entry_bytes_24_31,
   input  logic                csr_wr_en,
   input  logic [8:0]          csr_wr_data,
   fla_rsp_if.source           rsp
);
   import fla_pkg::*;

   localparam int DEPTH = MAX_FRAGMENTS * UNITS_PER_FRAG;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = $clog2(MAX_FRAGMENTS + 1);

   logic [255:0] entry_ff;
   logic [7:0]   eb [32];
   logic [8:0]   cap_ff, cap_in, capm;
   logic         chain_valid_ff, chain_valid_in;
   logic [7:0]   chain_sum_ff, chain_sum_in;
   logic [8:0]   count_ff, count_in;
   logic [MAX_FRAGMENTS-1:0] rowv_ff, rowv_in;
   logic [8:0]   i_ff, i_in;
   logic [RW-1:0] r_ff, r_in, rrow_ff;
   logic [3:0]   c_ff, c_in;
   logic         q_ok_ff, q_ok_in;
   logic [7:0]   sum_ff, sum_in;
   logic [3:0]   k_ff, k_in;
   logic [8:0]   o_ff, o_in;
   logic [1:0]   b_ff, b_in;
   logic [8:0]   p_ff, p_in;
   logic [8:0]   elen_ff, elen_in;
   logic         lng_ff, lng_in;
   logic [63:0]  chunk_ff, chunk_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic         rv_ff, rv_in;
   logic         rkind_ff, rkind_in, rlast_ff, rlast_in, rlng_ff, rlng_in;
   logic [63:0]  rchunk_ff, rchunk_in;
   logic [3:0]   rbytes_ff, rbytes_in;
   logic [7:0]   rattr_ff, rattr_in;
   logic [31:0]  rclus_ff, rclus_in, rsize_ff, rsize_in;

   logic [5:0]   seq, seq_m1;
   logic         head;
   logic         we;
   logic [15:0]  wdata, q, unit;
   logic [4:0]   off;
   logic [1:0]   nb;
   logic         term, sur, ovf, at_end, pre_ok, advance;
   logic         out_free, push_en;
   logic [7:0]   push_byte;
   logic [3:0]   nlen, slen, xk;
   logic [1:0]   xlen;
   logic         seen, has_ext;
   logic [7:0]   sbyte;

   // Entry byte view.
   always_comb begin
      for (int j = 0; j < 32; j++) begin
         eb[j] = entry_ff[8*j +: 8];
      end
   end

   assign seq    = eb[0][5:0];
   assign seq_m1 = seq - 6'd1;
   assign head   = eb[0][ORDER_HEAD_BIT];
   assign capm   = (cap_ff > CAP_MAX) ? CAP_MAX : cap_ff;

   // Unit store.
   assign off   = UNIT_OFFSETS[c_ff];
   assign wdata = {eb[5'(off + 5'd1)], eb[off]};
   assign we    = cmd.frag_write;

   fla_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (i_ff[AW-1:0]),
      .wr_data (wdata),
      .rd_addr (i_ff[AW-1:0]),
      .rd_data (q)
   );

   // A row never written since reset reads as zero units.
   assign unit   = rowv_ff[rrow_ff] ? q : 16'h0000;
   assign nb     = utf8_len(unit);
   assign term   = (unit == 16'h0000) || (unit == UNIT_FILL);
   assign sur    = (unit >= SURR_LO) && (unit <= SURR_HI);
   assign ovf    = ({1'b0, o_ff} + {8'd0, nb}) >= {1'b0, capm};
   assign at_end = (i_ff == count_ff);
   assign pre_ok = chain_valid_ff && (count_ff != 9'd0) && (chain_sum_ff == sum_ff);

   // Trimmed 8.3 name: base length, extension length, byte at position p.
   always_comb begin
      nlen = 4'd0;
      seen = 1'b0;
      for (int j = 0; j < 8; j++) begin
         if (!seen) begin
            if (eb[j] == 8'h00) seen = 1'b1;
            else if (eb[j] != CHAR_SPACE) nlen = 4'(j + 1);
         end
      end
      xlen = 2'd0;
      seen = 1'b0;
      for (int j = 0; j < 3; j++) begin
         if (!seen) begin
            if (eb[8+j] == 8'h00) seen = 1'b1;
            else if (eb[8+j] != CHAR_SPACE) xlen = 2'(j + 1);
         end
      end
      has_ext = (eb[8] != CHAR_SPACE);
      slen    = has_ext ? (nlen + 4'd1 + {2'b00, xlen}) : nlen;
      xk      = p_ff[3:0] - nlen - 4'd1;
      if (p_ff[3:0] < nlen) sbyte = eb[{2'b00, p_ff[2:0]}];
      else if (p_ff[3:0] == nlen) sbyte = CHAR_DOT;
      else begin
         case (xk[1:0])
            2'd0:    sbyte = eb[8];
            2'd1:    sbyte = eb[9];
            default: sbyte = eb[10];
         endcase
      end
   end

   assign out_free = !rv_ff || rsp.ready;

   // Status to the controller.
   always_comb begin
      if (eb[0] == BYTE_END) status.kind = K_END;
      else if (eb[0] == BYTE_DELETED) status.kind = K_DEL;
      else if (eb[11] == ATTR_LFN) status.kind = K_FRAG;
      else if (eb[11][ATTR_VOL_BIT]) status.kind = K_VOL;
      else status.kind = K_SHORT;
      status.frag_ok   = (seq != 6'd0) && ({1'b0, seq} <= 7'(MAX_FRAGMENTS)) &&
                         (head || (chain_valid_ff && (eb[13] == chain_sum_ff)));
      status.col_last  = (c_ff == 4'(UNITS_PER_FRAG - 1));
      status.sum_last  = (k_ff == 4'd10);
      status.scan_done = !pre_ok || at_end || (q_ok_ff && (term || sur || ovf));
      status.scan_ok   = pre_ok && (at_end || (q_ok_ff && term)) && (o_ff != 9'd0);
      status.emit_done = (p_ff == elen_ff);
      status.out_free  = out_free;
   end

   // Byte source for the word packer.
   always_comb begin
      push_en   = 1'b0;
      push_byte = sbyte;
      advance   = 1'b0;
      if (cmd.emit_step && !status.emit_done && (cnt_ff != 4'd8 || out_free)) begin
         if (lng_ff) begin
            push_en   = q_ok_ff;
            push_byte = utf8_byte(unit, b_ff);
            advance   = q_ok_ff && (b_ff == nb - 2'd1);
         end else begin
            push_en = 1'b1;
         end
      end
      if (cmd.scan_step && !status.scan_done && q_ok_ff) advance = 1'b1;
   end

   // Next-state logic of the datapath registers.
   always_comb begin
      cap_in         = csr_wr_en ? csr_wr_data : cap_ff;
      chain_valid_in = chain_valid_ff;
      chain_sum_in   = chain_sum_ff;
      count_in       = count_ff;
      rowv_in        = rowv_ff;
      i_in           = i_ff;
      r_in           = r_ff;
      c_in           = c_ff;
      q_ok_in        = 1'b1;
      sum_in         = sum_ff;
      k_in           = k_ff;
      o_in           = o_ff;
      b_in           = b_ff;
      p_in           = p_ff;
      elen_in        = elen_ff;
      lng_in         = lng_ff;
      chunk_in       = chunk_ff;
      cnt_in         = cnt_ff;
      rv_in          = rv_ff && !rsp.ready;
      rkind_in       = rkind_ff;
      rchunk_in      = rchunk_ff;
      rbytes_in      = rbytes_ff;
      rlast_in       = rlast_ff;
      rlng_in        = rlng_ff;
      rattr_in       = rattr_ff;
      rclus_in       = rclus_ff;
      rsize_in       = rsize_ff;

      if (cmd.chain_clear || cmd.send_last) begin
         chain_valid_in = 1'b0;
         chain_sum_in   = 8'd0;
         count_in       = 9'd0;
      end

      // Fragment: update the chain and point at its slot.
      if (cmd.frag_start) begin
         if (head) begin
            chain_valid_in = 1'b1;
            chain_sum_in   = eb[13];
            count_in       = 9'({3'b000, seq} * 9'(UNITS_PER_FRAG));
         end
         rowv_in[seq_m1[RW-1:0]] = 1'b1;
         i_in = 9'({3'b000, seq_m1} * 9'(UNITS_PER_FRAG));
         c_in = 4'd0;
      end
      if (cmd.frag_write) begin
         i_in = i_ff + 9'd1;
         c_in = c_ff + 4'd1;
      end

      // Short entry: restart walk, checksum and packer; a long name restarts the walk only.
      if (cmd.walk_start || cmd.long_start) begin
         i_in    = 9'd0;
         r_in    = '0;
         c_in    = 4'd0;
         q_ok_in = 1'b0;
         b_in    = 2'd0;
         p_in    = 9'd0;
      end
      if (cmd.walk_start) begin
         sum_in   = 8'd0;
         k_in     = 4'd0;
         o_in     = 9'd0;
         cnt_in   = 4'd0;
         chunk_in = 64'd0;
      end
      if (cmd.sum_step) begin
         sum_in = {sum_ff[0], sum_ff[7:1]} + eb[{1'b0, k_ff}];
         k_in   = k_ff + 4'd1;
      end
      if (cmd.scan_step && advance) begin
         o_in = o_ff + {7'd0, nb};
      end
      if (cmd.long_start) begin
         elen_in = o_ff;
         lng_in  = 1'b1;
      end
      if (cmd.short_start) begin
         p_in    = 9'd0;
         elen_in = {5'd0, slen};
         lng_in  = 1'b0;
      end

      // Walk one unit further through the store.
      if (advance) begin
         i_in    = i_ff + 9'd1;
         q_ok_in = 1'b0;
         if (c_ff == 4'(UNITS_PER_FRAG - 1)) begin
            c_in = 4'd0;
            r_in = r_ff + RW'(1);
         end else begin
            c_in = c_ff + 4'd1;
         end
      end

      // Pack one name byte; a full word leaves first when another byte follows.
      if (push_en) begin
         p_in = p_ff + 9'd1;
         if (lng_ff) b_in = advance ? 2'd0 : b_ff + 2'd1;
         if (cnt_ff == 4'd8) begin
            rv_in     = 1'b1;
            rkind_in  = 1'b0;
            rchunk_in = chunk_ff;
            rbytes_in = cnt_ff;
            rlast_in  = 1'b0;
            rlng_in   = lng_ff;
            rattr_in  = eb[11];
            rclus_in  = {eb[21], eb[20], eb[27], eb[26]};
            rsize_in  = {eb[31], eb[30], eb[29], eb[28]};
            chunk_in  = {56'd0, push_byte};
            cnt_in    = 4'd1;
         end else begin
            chunk_in[{cnt_ff[2:0], 3'b000} +: 8] = push_byte;
            cnt_in = cnt_ff + 4'd1;
         end
      end

      if (cmd.send_last) begin
         rv_in     = 1'b1;
         rkind_in  = 1'b0;
         rchunk_in = chunk_ff;
         rbytes_in = cnt_ff;
         rlast_in  = 1'b1;
         rlng_in   = lng_ff;
         rattr_in  = eb[11];
         rclus_in  = {eb[21], eb[20], eb[27], eb[26]};
         rsize_in  = {eb[31], eb[30], eb[29], eb[28]};
      end
      if (cmd.send_end) begin
         rv_in     = 1'b1;
         rkind_in  = 1'b1;
         rchunk_in = 64'd0;
         rbytes_in = 4'd0;
         rlast_in  = 1'b1;
         rlng_in   = 1'b0;
         rattr_in  = 8'd0;
         rclus_in  = 32'd0;
         rsize_in  = 32'd0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff         <= CAP_RESET;
         chain_valid_ff <= 1'b0;
         chain_sum_ff   <= 8'd0;
         count_ff       <= 9'd0;
         rowv_ff        <= '0;
         rv_ff          <= 1'b0;
         q_ok_ff        <= 1'b0;
      end else begin
         cap_ff         <= cap_in;
         chain_valid_ff <= chain_valid_in;
         chain_sum_ff   <= chain_sum_in;
         count_ff       <= count_in;
         rowv_ff        <= rowv_in;
         rv_ff          <= rv_in;
         q_ok_ff        <= q_ok_in;
      end
   end

   // Payload and walk registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         entry_ff <= {entry_bytes_24_31, entry_bytes_16_23, entry_bytes_8_15,
                      entry_bytes_0_7};
      end
      i_ff      <= i_in;
      r_ff      <= r_in;
      rrow_ff   <= r_ff;
      c_ff      <= c_in;
      sum_ff    <= sum_in;
      k_ff      <= k_in;
      o_ff      <= o_in;
      b_ff      <= b_in;
      p_ff      <= p_in;
      elen_ff   <= elen_in;
      lng_ff    <= lng_in;
      chunk_ff  <= chunk_in;
      cnt_ff    <= cnt_in;
      rkind_ff  <= rkind_in;
      rchunk_ff <= rchunk_in;
      rbytes_ff <= rbytes_in;
      rlast_ff  <= rlast_in;
      rlng_ff   <= rlng_in;
      rattr_ff  <= rattr_in;
      rclus_ff  <= rclus_in;
      rsize_ff  <= rsize_in;
   end

   assign rsp.valid          = rv_ff;
   assign rsp.result_kind    = rkind_ff;
   assign rsp.name_chunk     = rchunk_ff;
   assign rsp.chunk_bytes    = rbytes_ff;
   assign rsp.is_last        = rlast_ff;
   assign rsp.long_name_used = rlng_ff;
   assign rsp.is_directory   = rattr_ff[ATTR_DIR_BIT];
   assign rsp.attributes     = rattr_ff;
   assign rsp.start_cluster  = rclus_ff;
   assign rsp.file_size      = rsize_ff;
endmodule

>>> sv/fat_long_name_assembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_long_name_assembler
// Assembles long file names from directory entries and emits them as UTF-8.
// ----------------------------------------------------------------------------
// Usage: one 32-byte directory entry is taken per word on req_chan. Long-name
// fragments are stored and produce no word; an end marker gives one end word;
// a short entry gives its long name (or the trimmed 8.3 name) in words of up
// to eight bytes on rsp_chan, the last one flagged.
// Sequence: one entry at a time. A fragment is decoded and makes 13 store writes.
// A short entry is accepted, decoded and checksummed, then the stored units
// are scanned for validity (bounded by the store read port), then the name
// bytes are emitted, for a long name with each unit waiting for its store
// read, and the last word is sent. Deleted entries and volume labels are
// decoded and dropped; an end marker is decoded and gives its end word.
// Reset: the chain is cleared, capacity returns to 64 and the per-fragment
// row valid bits clear at once, so no clearing pass of the store is needed.
// Stall: a finished word waits in the output register while the next bytes
// are packed; packing stops only when a second word is ready.
// csr_wr_data sets the name capacity; write it only while idle.
// ----------------------------------------------------------------------------
module fat_long_name_assembler #(
   parameter int MAX_FRAGMENTS = fla_pkg::MAX_FRAGMENTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   fla_req_if.sink    req_chan,
   fla_rsp_if.source  rsp_chan,
   input  logic       csr_wr_en,
   input  logic [8:0] csr_wr_data
);
   import fla_pkg::*;
   `include "assert_macros.svh"

   cmd_type    cmd;
   status_type status;

   // Controller.
   fla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   fla_dp #(.MAX_FRAGMENTS(MAX_FRAGMENTS)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .entry_bytes_0_7   (req_chan.entry_bytes_0_7),
      .entry_bytes_8_15  (req_chan.entry_bytes_8_15),
      .entry_bytes_16_23 (req_chan.entry_bytes_16_23),
      .entry_bytes_24_31 (req_chan.entry_bytes_24_31),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp               (rsp_chan)
   );

   // Checks.
   `ASSERT_NEXT(a_one_entry, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   `ASSERT_IMPLY(a_end_last, clock, reset, rsp_chan.valid && rsp_chan.result_kind, rsp_chan.is_last)
   `ASSERT_IMPLY(a_full_words, clock, reset, rsp_chan.valid && !rsp_chan.is_last, rsp_chan.chunk_bytes == 4'd8)
endmodule
